@@ sv/radar_rain_detector_defines.svh @@
// Assertion macros for the rain detector.
`ifndef RADAR_RAIN_DETECTOR_DEFINES_SVH
`define RADAR_RAIN_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define RRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// Next-cycle implication, checked while out of reset.
`define RRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define RRD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rrd_pkg.sv @@
// Shared types and constants for the rain detector.
`default_nettype none

package rrd_pkg;

    localparam logic [1:0] CMD_BIN   = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] CFG_RAIN_DBZ  = 2'd0;
    localparam logic [1:0] CFG_AREA_THR  = 2'd1;
    localparam logic [1:0] CFG_DRY_MIN   = 2'd2;
    localparam logic [1:0] CFG_BEAM_SINE = 2'd3;

    localparam logic signed [10:0] BIAS_OFFSET      = 11'sd66;
    localparam logic [10:0]        RANGE_BINS       = 11'd256;
    localparam logic [31:0]        SECONDS_PER_HOUR = 32'd3600;
    localparam logic [25:0]        SUM_MAX          = 26'h3FFFFFF;
    localparam logic [19:0]        AREA_MAX         = 20'hFFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  bin_value;
        logic [7:0]  range_index;
        logic [31:0] time_seconds;
    } in_t;

    typedef struct packed {
        logic        rain_detected;
        logic        reset_total_flag;
        logic        precip_begin_flag;
        logic [19:0] rain_area_km2;
    } out_t;

    // Word between the accumulate stage and the decision stage.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] time_seconds;
        logic [24:0] area;
    } stage_t;

endpackage

`default_nettype wire

@@ sv/rrd_accum.sv @@
// Bin accumulation and area multiply stage.
`default_nettype none

module rrd_accum
    import rrd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire in_t                item,
    input  wire logic signed [7:0]  rain_dbz,
    input  wire logic [15:0]        beam_sine_q16,
    output stage_t                  stage
);

    logic [25:0]        sum_reg;
    logic [25:0]        sum_next;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic signed [10:0] thr;
    logic               counts;
    logic [26:0]        sum_add;
    logic [41:0]        product;

    // biased threshold = 2*dBZ + 66
    assign thr = $signed({{2{rain_dbz[7]}}, rain_dbz, 1'b0}) + BIAS_OFFSET;

    assign counts = !item.bin_value[8]
                 && ({3'b000, item.range_index} < RANGE_BINS)
                 && ($signed({2'b00, item.bin_value}) >= thr);

    // 2*range+1 added to the running sum
    assign sum_add = {1'b0, sum_reg} + {18'd0, item.range_index, 1'b1};
    assign product = 42'(sum_reg) * 42'(beam_sine_q16);

    always_comb
    begin
        sum_next = sum_reg;
        case (item.cmd)
            CMD_BIN:
            begin
                if (counts)
                begin
                    sum_next = sum_add[26] ? SUM_MAX : sum_add[25:0];
                end
            end
            CMD_EVAL:
            begin
                sum_next = '0;
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
        stage_next.cmd          = item.cmd;
        stage_next.time_seconds = item.time_seconds;
        stage_next.area         = product[41:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

@@ sv/rrd_decide.sv @@
// Rain decision, dry timer and flag stage.
`default_nettype none

module rrd_decide
    import rrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire stage_t      stage,
    input  wire logic [19:0] area_threshold_km2,
    input  wire logic [10:0] dry_minutes,
    output out_t             result
);

    logic [31:0] last_rain_time_reg;
    logic [31:0] last_rain_time_next;
    logic        previous_reset_reg;
    logic        previous_reset_next;
    logic        detected;
    logic [16:0] limit;
    logic [31:0] diff;
    logic        reset_flag;

    assign detected = stage.area >= {5'd0, area_threshold_km2};
    // minutes * 60 as (m << 6) - (m << 2)
    assign limit    = {dry_minutes, 6'd0} - {4'd0, dry_minutes, 2'd0};
    assign diff     = stage.time_seconds - last_rain_time_reg;
    // time running backwards reads negative and never resets
    assign reset_flag = !detected && !diff[31] && (diff >= {15'd0, limit});

    assign result.rain_detected     = detected;
    assign result.reset_total_flag  = reset_flag;
    assign result.precip_begin_flag = previous_reset_reg && !reset_flag;
    assign result.rain_area_km2     = (stage.area > {5'd0, AREA_MAX}) ? AREA_MAX
                                                                      : stage.area[19:0];

    always_comb
    begin
        last_rain_time_next = last_rain_time_reg;
        previous_reset_next = previous_reset_reg;
        case (stage.cmd)
            CMD_EVAL:
            begin
                if (detected)
                begin
                    last_rain_time_next = stage.time_seconds;
                end
                previous_reset_next = reset_flag;
            end
            CMD_START:
            begin
                last_rain_time_next = stage.time_seconds - SECONDS_PER_HOUR;
                previous_reset_next = 1'b1;
            end
            default:
            begin
                last_rain_time_next = last_rain_time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rain_time_reg <= '0;
            previous_reset_reg <= 1'b1;
        end
        else if (advance)
        begin
            last_rain_time_reg <= last_rain_time_next;
            previous_reset_reg <= previous_reset_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/radar_rain_detector.sv @@
// Rain detector over hybrid-scan bins, one word accepted per cycle unless stalled.
// An evaluate word passes the input, accumulate and output registers in order.
// Throughput: one word per cycle unless stalled; the input, accumulate and output
// registers each hold one word, so only a stalled result holds the input back.
// Reset (rst_n low, async): config regs to defaults, sum and last rain time to 0,
// previous reset state to 1, pipeline empty.
`default_nettype none
`include "radar_rain_detector_defines.svh"

module radar_rain_detector
    import rrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    // input words
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    // result words
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data
);

    // Config registers
    logic signed [7:0] rain_dbz_reg;
    logic [19:0]       area_thr_reg;
    logic [10:0]       dry_min_reg;
    logic [15:0]       beam_sine_reg;

    // Pipeline: s1 input register, s2 accumulate register, output register
    logic   s1_valid_reg;
    logic   s1_valid_next;
    in_t    s1_data_reg;
    logic   s2_valid_reg;
    logic   s2_valid_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    out_t   out_data_reg;

    stage_t s2_stage;
    out_t   result;

    logic   ready2;
    logic   ready3;
    logic   in_take;
    logic   move1;
    logic   move2;
    logic   eval_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rain_dbz_reg  <= 8'sd20;
            area_thr_reg  <= 20'd80;
            dry_min_reg   <= 11'd60;
            beam_sine_reg <= 16'd1144;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RAIN_DBZ:  rain_dbz_reg  <= $signed(cfg_data[7:0]);
                CFG_AREA_THR:  area_thr_reg  <= cfg_data;
                CFG_DRY_MIN:   dry_min_reg   <= cfg_data[10:0];
                CFG_BEAM_SINE: beam_sine_reg <= cfg_data[15:0];
                default:       rain_dbz_reg  <= rain_dbz_reg;
            endcase
        end
    end

    // Each stage loads when it is empty or its word moves on.
    assign ready3   = !out_valid_reg || !out_stall;
    assign ready2   = !s2_valid_reg || ready3;
    assign move2    = s2_valid_reg && ready3;
    assign move1    = s1_valid_reg && ready2;
    assign in_stall = s1_valid_reg && !ready2;
    assign in_take  = in_valid && !in_stall;
    // only evaluate words produce a result
    assign eval_out = move2 && (s2_stage.cmd == CMD_EVAL);

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (move1 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = move1 ? 1'b1 : (move2 ? 1'b0 : s2_valid_reg);
        out_valid_next = eval_out ? 1'b1 : (ready3 ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (eval_out)
        begin
            out_data_reg <= result;
        end
    end

    // Threshold test, saturating weighted sum, sum * sine product
    rrd_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (move1),
        .item          (s1_data_reg),
        .rain_dbz      (rain_dbz_reg),
        .beam_sine_q16 (beam_sine_reg),
        .stage         (s2_stage)
    );

    // Area compare, dry timer, storm-total and precip-begin flags
    rrd_decide u_decide (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (move2),
        .stage              (s2_stage),
        .area_threshold_km2 (area_thr_reg),
        .dry_minutes        (dry_min_reg),
        .result             (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An evaluate leaving stage two always shows up as a result word.
    `RRD_ASSERT_NEXT(a_eval_gives_result, clk, rst_n, eval_out, out_valid_reg)
    // A result word appears only after an evaluate left stage two.
    `RRD_ASSERT_NOW(a_result_from_eval, clk, rst_n, $rose(out_valid_reg), $past(eval_out))
    // Rain seen means the dry timer cannot have run out.
    `RRD_ASSERT_NOW(a_rain_not_dry, clk, rst_n, out_valid_reg && out_data_reg.rain_detected, !out_data_reg.reset_total_flag)
    // Input is held back only while the input register is full.
    `RRD_ASSERT_NOW(a_stall_needs_full, clk, rst_n, in_stall, s1_valid_reg)

endmodule

`default_nettype wire
